FILE: src/tspa_pkg.sv
package tspa_pkg;

  localparam int BYTE_W = 8;
  localparam int LIMIT_W = 12;

  localparam logic [BYTE_W-1:0] SYNC_VALUE_RESET = 8'd71;
  localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RESET = 12'd564;
  localparam logic [LIMIT_W-1:0] SKIP_MAX = 12'hFFF;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_SYNC_VALUE = 1'b0,
    REG_SEARCH_LIMIT = 1'b1
  } tspa_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_value;
    logic [LIMIT_W-1:0] search_limit;
  } tspa_cfg_t;

  // What the delay line shows about the byte under judgement.
  typedef struct packed {
    logic all_match;
    logic oldest_is_sync;
    logic [BYTE_W-1:0] oldest;
  } tspa_taps_t;

  typedef struct packed {
    logic byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic packet_start;
    logic packet_end;
    logic [LIMIT_W-1:0] skipped_bytes;
    logic search_gave_up;
  } tspa_result_t;

endpackage

FILE: src/ts_packet_sync_aligner.sv
// Transport stream sync aligner: raw stream bytes enter on the in channel, one
// beat per clock while in_stall is low, and pass through a delay line of
// (MATCH_COUNT-1)*PACKET_BYTES+1 bytes. While searching, the oldest byte starts
// a packet only when it and the bytes one to MATCH_COUNT-1 packet lengths later
// all equal sync_value; other bytes are dropped and counted, and a give-up beat
// (search_gave_up, no byte) is sent each time the count reaches search_limit.
// Once locked, every packet byte leaves with packet_start/packet_end marks, and
// a first byte that is not sync_value drops lock and that byte. No beat leaves
// until the line has filled, which takes the first (MATCH_COUNT-1)*PACKET_BYTES+1
// input beats. Each beat is held in an input register, judged by parallel tap
// compares and lands in the output register, so the block sustains one beat per
// clock whenever out_stall is low.
module ts_packet_sync_aligner #(
  parameter int PACKET_BYTES = 188,
  parameter int MATCH_COUNT = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [tspa_pkg::BYTE_W-1:0] in_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic byte_valid,
  output logic [tspa_pkg::BYTE_W-1:0] out_byte,
  output logic packet_start,
  output logic packet_end,
  output logic [tspa_pkg::LIMIT_W-1:0] skipped_bytes,
  output logic search_gave_up,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [tspa_pkg::PADDR_W-1:0] paddr,
  input  logic [tspa_pkg::PDATA_W-1:0] pwdata,
  output logic [tspa_pkg::PDATA_W-1:0] prdata,
  output logic pready
);
  import tspa_pkg::*;

  tspa_cfg_t cfg;
  tspa_taps_t taps;
  tspa_result_t result;
  logic shift_en;
  logic [BYTE_W-1:0] line_byte;

  tspa_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  tspa_delay_line #(
    .PACKET_BYTES(PACKET_BYTES),
    .MATCH_COUNT(MATCH_COUNT)
  ) u_line (
    .clk(clk),
    .shift_en(shift_en),
    .new_byte(line_byte),
    .sync_value(cfg.sync_value),
    .taps(taps)
  );

  tspa_align_ctrl #(
    .PACKET_BYTES(PACKET_BYTES),
    .MATCH_COUNT(MATCH_COUNT)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result(result),
    .cfg(cfg),
    .shift_en(shift_en),
    .line_byte(line_byte),
    .taps(taps)
  );

  assign byte_valid = result.byte_valid;
  assign out_byte = result.out_byte;
  assign packet_start = result.packet_start;
  assign packet_end = result.packet_end;
  assign skipped_bytes = result.skipped_bytes;
  assign search_gave_up = result.search_gave_up;

endmodule

FILE: src/tspa_cfg_regs.sv
module tspa_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [tspa_pkg::PADDR_W-1:0] paddr,
  input  logic [tspa_pkg::PDATA_W-1:0] pwdata,
  output logic [tspa_pkg::PDATA_W-1:0] prdata,
  output logic pready,
  output tspa_pkg::tspa_cfg_t cfg
);
  import tspa_pkg::*;

  tspa_reg_t reg_sel;
  logic wr_en;

  assign pready = 1'b1;
  assign reg_sel = tspa_reg_t'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value <= SYNC_VALUE_RESET;
      cfg.search_limit <= SEARCH_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SYNC_VALUE: cfg.sync_value <= pwdata[BYTE_W-1:0];
        REG_SEARCH_LIMIT: cfg.search_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SYNC_VALUE: prdata = {{(PDATA_W-BYTE_W){1'b0}}, cfg.sync_value};
      REG_SEARCH_LIMIT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cfg.search_limit};
      default: prdata = '0;
    endcase
  end

endmodule

FILE: src/tspa_delay_line.sv
module tspa_delay_line #(
  parameter int PACKET_BYTES = 188,
  parameter int MATCH_COUNT = 4
) (
  input  logic clk,
  input  logic shift_en,
  input  logic [tspa_pkg::BYTE_W-1:0] new_byte,
  input  logic [tspa_pkg::BYTE_W-1:0] sync_value,
  output tspa_pkg::tspa_taps_t taps
);
  import tspa_pkg::*;

  // The incoming byte is the newest tap, so only the older bytes need storage.
  localparam int STORE_DEPTH = (MATCH_COUNT - 1) * PACKET_BYTES;

  logic [BYTE_W-1:0] line [STORE_DEPTH];
  logic [MATCH_COUNT-1:0] tap_hit;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      line[0] <= new_byte;
      for (int i = 1; i < STORE_DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  // Tap n sits n packet lengths after the oldest byte.
  for (genvar n = 0; n < MATCH_COUNT - 1; n++) begin : g_tap
    assign tap_hit[n] = (line[(MATCH_COUNT-1-n)*PACKET_BYTES-1] == sync_value);
  end
  assign tap_hit[MATCH_COUNT-1] = (new_byte == sync_value);

  assign taps.oldest = line[STORE_DEPTH-1];
  assign taps.oldest_is_sync = tap_hit[0];
  assign taps.all_match = &tap_hit;

endmodule

FILE: src/tspa_align_ctrl.sv
module tspa_align_ctrl #(
  parameter int PACKET_BYTES = 188,
  parameter int MATCH_COUNT = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [tspa_pkg::BYTE_W-1:0] in_byte,
  output logic out_valid,
  input  logic out_stall,
  output tspa_pkg::tspa_result_t result,
  input  tspa_pkg::tspa_cfg_t cfg,
  output logic shift_en,
  output logic [tspa_pkg::BYTE_W-1:0] line_byte,
  input  tspa_pkg::tspa_taps_t taps
);
  import tspa_pkg::*;

  localparam int LINE_DEPTH = (MATCH_COUNT - 1) * PACKET_BYTES + 1;
  localparam int FILL_W = $clog2(LINE_DEPTH + 1);
  localparam int POS_W = $clog2(PACKET_BYTES);

  logic in_reg_valid;
  logic [BYTE_W-1:0] in_reg_byte;
  logic out_free;
  logic advance;

  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_count_next;
  logic locked;
  logic locked_next;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic [LIMIT_W-1:0] skip_count;
  logic [LIMIT_W-1:0] skip_count_next;
  logic [LIMIT_W-1:0] skip_inc;
  logic line_full;
  logic last_byte;
  logic res_valid;
  tspa_result_t res;

  assign out_free = !out_valid || !out_stall;
  assign advance = in_reg_valid && out_free;
  assign in_stall = in_reg_valid && !out_free;
  assign shift_en = advance;
  assign line_byte = in_reg_byte;

  // The line is full once this beat lands in it.
  assign line_full = (fill_count >= FILL_W'(LINE_DEPTH - 1));
  assign last_byte = (position == POS_W'(PACKET_BYTES - 1));
  assign skip_inc = (skip_count == SKIP_MAX) ? skip_count : skip_count + 1'b1;

  always_comb begin
    fill_count_next = line_full ? FILL_W'(LINE_DEPTH) : fill_count + 1'b1;
    locked_next = locked;
    position_next = position;
    skip_count_next = skip_count;
    res_valid = 1'b0;
    res = '0;
    if (line_full) begin
      if (locked) begin
        if (position == '0) begin
          if (!taps.oldest_is_sync) begin
            // Lost sync: drop this beat and restart the search.
            locked_next = 1'b0;
            skip_count_next = '0;
          end else begin
            position_next = POS_W'(1);
            res_valid = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte = taps.oldest;
            res.packet_start = 1'b1;
            res.packet_end = (PACKET_BYTES == 1);
          end
        end else begin
          position_next = last_byte ? '0 : position + 1'b1;
          res_valid = 1'b1;
          res.byte_valid = 1'b1;
          res.out_byte = taps.oldest;
          res.packet_end = last_byte;
        end
      end else if (taps.all_match) begin
        locked_next = 1'b1;
        skip_count_next = '0;
        position_next = POS_W'(1);
        res_valid = 1'b1;
        res.byte_valid = 1'b1;
        res.out_byte = taps.oldest;
        res.packet_start = 1'b1;
        res.packet_end = (PACKET_BYTES == 1);
        res.skipped_bytes = skip_count;
      end else if (skip_inc >= cfg.search_limit) begin
        skip_count_next = '0;
        res_valid = 1'b1;
        res.skipped_bytes = skip_inc;
        res.search_gave_up = 1'b1;
      end else begin
        skip_count_next = skip_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid <= 1'b0;
      fill_count <= '0;
      locked <= 1'b0;
      position <= '0;
      skip_count <= '0;
    end else begin
      if (!in_stall) begin
        in_reg_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= advance && res_valid;
      end
      if (advance) begin
        fill_count <= fill_count_next;
        locked <= locked_next;
        position <= position_next;
        skip_count <= skip_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= in_byte;
    end
    if (advance && res_valid) begin
      result <= res;
    end
  end

endmodule

FILE: src/tspa_checker.sv
module tspa_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic byte_valid,
  input logic [tspa_pkg::BYTE_W-1:0] out_byte,
  input logic packet_start,
  input logic packet_end,
  input logic [tspa_pkg::LIMIT_W-1:0] skipped_bytes,
  input logic search_gave_up
);
  import tspa_pkg::*;

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(skipped_bytes))
    else $error("stalled output beat changed");

  // A beat without a byte is only ever a give-up report.
  a_give_up_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> search_gave_up)
    else $error("empty beat without give-up flag");

  a_give_up_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && search_gave_up |->
      !byte_valid && !packet_start && !packet_end && out_byte == '0)
    else $error("give-up beat carries packet data");

  a_skip_on_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid && !packet_start |-> skipped_bytes == '0)
    else $error("skip count outside a packet start");

  a_end_not_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> byte_valid && !packet_start)
    else $error("packet end on a start or empty beat");

endmodule

bind ts_packet_sync_aligner tspa_checker u_chk (.*);
